/* rtl/lod_pkg.sv */
package lod_pkg;

  localparam int unsigned NumRegs     = 7;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 16;
  localparam int unsigned StillCntW   = 9;
  localparam int unsigned PhaseCntW   = 13;

  localparam logic [StillCntW-1:0] StillCntMax = '1;
  localparam logic [PhaseCntW-1:0] PhaseCntMax = '1;

  // register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_STILL_THR  = 3'd0,
    REG_STILL_PER  = 3'd1,
    REG_ACCEL_THR  = 3'd2,
    REG_PITCH_WIN  = 3'd3,
    REG_LIFT_TMO   = 3'd4,
    REG_SPIN_TMO   = 3'd5,
    REG_SPIN_THR   = 3'd6
  } reg_idx_e;

  localparam logic [15:0] StillThrRst = 16'd30;
  localparam logic [7:0]  StillPerRst = 8'd10;
  localparam logic [14:0] AccelThrRst = 15'd26000;
  localparam logic [14:0] PitchWinRst = 15'd2000;
  localparam logic [11:0] LiftTmoRst  = 12'd200;
  localparam logic [11:0] SpinTmoRst  = 12'd100;
  localparam logic [15:0] SpinThrRst  = 16'd70;

  typedef enum logic [1:0] {
    PH_STILL = 2'd0,
    PH_LIFT  = 2'd1,
    PH_SPIN  = 2'd2
  } phase_e;

  typedef struct packed {
    logic [15:0] still_thr;
    logic [7:0]  still_per;
    logic [14:0] accel_thr;
    logic [14:0] pitch_win;
    logic [11:0] lift_tmo;
    logic [11:0] spin_tmo;
    logic [15:0] spin_thr;
  } cfg_t;

  // per-period sensor tests
  typedef struct packed {
    logic still;     // |left| + |right| below threshold
    logic lift_ok;   // accel high and pitch near level
    logic spin_ok;   // |left + right| above threshold
  } cond_t;

endpackage

/* rtl/lod_cond.sv */
module lod_cond
  import lod_pkg::*;
(
  input  cfg_t               cfg_i,
  input  logic signed [15:0] left_count_i,
  input  logic signed [15:0] right_count_i,
  input  logic signed [15:0] vertical_accel_i,
  input  logic signed [15:0] pitch_angle_i,
  output cond_t              cond_o
);

  logic signed [16:0] left_x, right_x, sum_lr;
  logic        [16:0] mag_l, mag_r, mag_sum;
  logic        [17:0] mag_tot;
  logic signed [16:0] win_p, win_n, accel_x, pitch_x;

  always_comb begin
    left_x  = 17'(left_count_i);
    right_x = 17'(right_count_i);
    mag_l   = left_x[16]  ? 17'(-left_x)  : 17'(left_x);
    mag_r   = right_x[16] ? 17'(-right_x) : 17'(right_x);
    mag_tot = 18'(mag_l) + 18'(mag_r);
    sum_lr  = left_x + right_x;
    mag_sum = sum_lr[16] ? 17'(-sum_lr) : 17'(sum_lr);

    accel_x = 17'(vertical_accel_i);
    pitch_x = 17'(pitch_angle_i);
    win_p   = signed'({2'b00, cfg_i.pitch_win});
    win_n   = -win_p;

    cond_o.still   = mag_tot < {2'b00, cfg_i.still_thr};
    cond_o.lift_ok = (accel_x > signed'({2'b00, cfg_i.accel_thr}))
                     && (pitch_x > win_n) && (pitch_x < win_p);
    cond_o.spin_ok = mag_sum > {1'b0, cfg_i.spin_thr};
  end

endmodule

/* rtl/lod_seq.sv */
module lod_seq
  import lod_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  cfg_t  cfg_i,
  input  cond_t cond_i,
  output logic  picked_o
);

  phase_e               phase_q, phase_d;
  logic [StillCntW-1:0] still_q, still_d;
  logic [PhaseCntW-1:0] lift_q, lift_d;
  logic [PhaseCntW-1:0] spin_q, spin_d;

  // phases fall through within one period
  logic still_done, reach_lift, lift_tmo_hit, reach_spin, spin_tmo_hit;
  logic [StillCntW-1:0] still_inc;
  logic [PhaseCntW-1:0] lift_inc, spin_inc;

  always_comb begin
    still_inc = cond_i.still ? ((still_q < StillCntMax) ? still_q + 1'b1 : still_q)
                             : '0;
    still_done   = still_inc > {1'b0, cfg_i.still_per};
    reach_lift   = (phase_q == PH_LIFT) || ((phase_q == PH_STILL) && still_done);
    lift_inc     = (lift_q < PhaseCntMax) ? lift_q + 1'b1 : lift_q;
    lift_tmo_hit = lift_inc > {1'b0, cfg_i.lift_tmo};
    reach_spin   = (phase_q == PH_SPIN) || (reach_lift && cond_i.lift_ok);
    spin_inc     = (spin_q < PhaseCntMax) ? spin_q + 1'b1 : spin_q;
    spin_tmo_hit = spin_inc > {1'b0, cfg_i.spin_tmo};
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    still_d = still_q;
    lift_d  = lift_q;
    spin_d  = spin_q;
    if (phase_q == PH_STILL) begin
      still_d = still_done ? '0 : still_inc;
    end
    if (reach_lift) begin
      lift_d  = lift_tmo_hit ? '0 : lift_inc;
      phase_d = lift_tmo_hit ? PH_STILL : PH_LIFT;
    end
    if (reach_spin) begin
      spin_d  = spin_tmo_hit ? '0 : spin_inc;
      phase_d = (spin_tmo_hit || cond_i.spin_ok) ? PH_STILL : PH_SPIN;
    end
  end

  // outputs
  always_comb begin
    picked_o = reach_spin && cond_i.spin_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_STILL;
      still_q <= '0;
      lift_q  <= '0;
      spin_q  <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      still_q <= still_d;
      lift_q  <= lift_d;
      spin_q  <= spin_d;
    end
  end

endmodule

/* rtl/lift_off_detector_core.sv */
// Lift-off detector for a two-wheel balancing robot: one request per control period.
// A request passes the input reg, then the result reg, before its result is valid.
// One request per cycle while out_stall_i is low; the sequencer is single-pass logic.
// Reset (rst_ni low, async): phase back to still-wait, all counters zero,
// registers to their defaults, both pipeline stages empty.
module lift_off_detector_core
  import lod_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic signed [15:0]  left_count_i,
  input  logic signed [15:0]  right_count_i,
  input  logic signed [15:0]  vertical_accel_i,
  input  logic signed [15:0]  pitch_angle_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                picked_up_o
);

  // ---------------- configuration registers ----------------
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.still_thr <= StillThrRst;
      cfg_q.still_per <= StillPerRst;
      cfg_q.accel_thr <= AccelThrRst;
      cfg_q.pitch_win <= PitchWinRst;
      cfg_q.lift_tmo  <= LiftTmoRst;
      cfg_q.spin_tmo  <= SpinTmoRst;
      cfg_q.spin_thr  <= SpinThrRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STILL_THR: cfg_q.still_thr <= cfg_wdata_i;
        REG_STILL_PER: cfg_q.still_per <= cfg_wdata_i[7:0];
        REG_ACCEL_THR: cfg_q.accel_thr <= cfg_wdata_i[14:0];
        REG_PITCH_WIN: cfg_q.pitch_win <= cfg_wdata_i[14:0];
        REG_LIFT_TMO:  cfg_q.lift_tmo  <= cfg_wdata_i[11:0];
        REG_SPIN_TMO:  cfg_q.spin_tmo  <= cfg_wdata_i[11:0];
        REG_SPIN_THR:  cfg_q.spin_thr  <= cfg_wdata_i;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  // Result reg frees when empty or being taken this cycle; stage 1 moves
  // only into a free result reg, and new requests come in behind it.
  logic s1_valid_q;
  logic out_valid_q;
  logic out_free, s1_fire, in_fire;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) s1_valid_q <= in_valid_i;
      if (out_free)    out_valid_q <= s1_valid_q;
    end
  end

  // ---------------- input register ----------------
  logic signed [15:0] left_q, right_q, accel_q, pitch_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      left_q  <= left_count_i;
      right_q <= right_count_i;
      accel_q <= vertical_accel_i;
      pitch_q <= pitch_angle_i;
    end
  end

  // ---------------- sensor tests and sequencer ----------------
  cond_t cond;
  logic  picked;

  lod_cond u_cond (
    .cfg_i            (cfg_q),
    .left_count_i     (left_q),
    .right_count_i    (right_q),
    .vertical_accel_i (accel_q),
    .pitch_angle_i    (pitch_q),
    .cond_o           (cond)
  );

  // state advances exactly once per request, as it leaves stage 1
  lod_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (s1_fire),
    .cfg_i    (cfg_q),
    .cond_i   (cond),
    .picked_o (picked)
  );

  // ---------------- result register ----------------
  logic picked_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) picked_q <= picked;
  end

  assign out_valid_o = out_valid_q;
  assign picked_up_o = picked_q;

endmodule

/* tb/sv/tb_lift_off_detector_core.sv */
module tb_lift_off_detector_core;
  import lod_pkg::*;

  // no register lives at this index; writes to it must be dropped
  localparam logic [CfgIdxW-1:0] RegIdxSpare = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic signed [15:0]  left_count_i = '0;
  logic signed [15:0]  right_count_i = '0;
  logic signed [15:0]  vertical_accel_i = '0;
  logic signed [15:0]  pitch_angle_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                picked_up_o;

  lift_off_detector_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .left_count_i    (left_count_i),
    .right_count_i   (right_count_i),
    .vertical_accel_i(vertical_accel_i),
    .pitch_angle_i   (pitch_angle_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .picked_up_o     (picked_up_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predicted detector state, tracks every accepted request
  cfg_t                 cfg_m = '{StillThrRst, StillPerRst, AccelThrRst, PitchWinRst,
                                  LiftTmoRst, SpinTmoRst, SpinThrRst};
  phase_e               phase_m = PH_STILL;
  logic [StillCntW-1:0] still_cnt_m = '0;
  logic [PhaseCntW-1:0] lift_cnt_m = '0;
  logic [PhaseCntW-1:0] spin_cnt_m = '0;

  bit          pickup_q[$];
  int unsigned fail_cnt = 0;
  int unsigned gap_pct = 20;
  int unsigned stall_pct = 20;
  int unsigned sink_hold = 0;
  bit          req_up = 1'b0;
  bit          exp_pick;

  // one control period through the sequencer; phases fall through in order
  function automatic bit lift_step(input logic signed [15:0] l, r, a, p);
    int sl, sr, sa, sp, win, wheel_abs, sum_abs;
    bit hit;
    sl = l;
    sr = r;
    sa = a;
    sp = p;
    win = cfg_m.pitch_win;
    wheel_abs = (sl < 0 ? -sl : sl) + (sr < 0 ? -sr : sr);
    sum_abs = sl + sr;
    if (sum_abs < 0) sum_abs = -sum_abs;
    hit = 1'b0;
    if (phase_m == PH_STILL) begin
      if (wheel_abs < int'(cfg_m.still_thr)) begin
        if (still_cnt_m != StillCntMax) still_cnt_m++;
      end else begin
        still_cnt_m = '0;
      end
      if (still_cnt_m > cfg_m.still_per) begin
        phase_m = PH_LIFT;
        still_cnt_m = '0;
      end
    end
    if (phase_m == PH_LIFT) begin
      if (lift_cnt_m != PhaseCntMax) lift_cnt_m++;
      if (lift_cnt_m > cfg_m.lift_tmo) begin
        lift_cnt_m = '0;
        phase_m = PH_STILL;
      end
      // a lift seen in the timeout period still wins
      if (sa > int'(cfg_m.accel_thr) && sp > -win && sp < win) phase_m = PH_SPIN;
    end
    if (phase_m == PH_SPIN) begin
      if (spin_cnt_m != PhaseCntMax) spin_cnt_m++;
      if (spin_cnt_m > cfg_m.spin_tmo) begin
        spin_cnt_m = '0;
        phase_m = PH_STILL;
      end
      if (sum_abs > int'(cfg_m.spin_thr)) begin
        phase_m = PH_STILL;
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pickup_q.size() == 0) begin
        $display("%0t: result with nothing expected, picked_up=%0b", $time, picked_up_o);
        fail_cnt++;
      end else begin
        exp_pick = pickup_q.pop_front();
        if (picked_up_o !== exp_pick) begin
          $display("%0t: picked_up expected %0b, got %0b", $time, exp_pick, picked_up_o);
          fail_cnt++;
        end
      end
    end
  end

  // receiver stall bursts
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        sink_hold = $urandom_range(1, 14);
    end
  end

  task automatic drop_valid();
    if (req_up) begin
      in_valid_i <= 1'b0;
      req_up = 1'b0;
    end
  endtask

  task automatic send_period(input logic signed [15:0] l, r, a, p);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      drop_valid();
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_up = 1'b1;
    left_count_i <= l;
    right_count_i <= r;
    vertical_accel_i <= a;
    pitch_angle_i <= p;
    do @(posedge clk_i); while (in_stall_o);
    pickup_q.push_back(lift_step(l, r, a, p));
  endtask

  task automatic wait_drained();
    drop_valid();
    while (pickup_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    case (idx)
      REG_STILL_THR: cfg_m.still_thr = d;
      REG_STILL_PER: cfg_m.still_per = d[7:0];
      REG_ACCEL_THR: cfg_m.accel_thr = d[14:0];
      REG_PITCH_WIN: cfg_m.pitch_win = d[14:0];
      REG_LIFT_TMO:  cfg_m.lift_tmo = d[11:0];
      REG_SPIN_TMO:  cfg_m.spin_tmo = d[11:0];
      REG_SPIN_THR:  cfg_m.spin_thr = d;
      default: ;
    endcase
  endtask

  // junk_hi puts random bits above each register's width
  task automatic load_settings(input cfg_t c, input bit junk_hi);
    logic [15:0] junk;
    junk = junk_hi ? 16'($urandom) : 16'h0;
    wait_drained();
    write_reg(REG_STILL_THR, c.still_thr);
    write_reg(REG_STILL_PER, {junk[15:8], c.still_per});
    write_reg(REG_ACCEL_THR, {junk[15], c.accel_thr});
    write_reg(REG_PITCH_WIN, {junk[15], c.pitch_win});
    write_reg(REG_LIFT_TMO, {junk[15:12], c.lift_tmo});
    write_reg(REG_SPIN_TMO, {junk[15:12], c.spin_tmo});
    write_reg(REG_SPIN_THR, c.spin_thr);
    write_reg(RegIdxSpare, 16'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.still_thr = $urandom_range(0, 9) < 7 ? 16'($urandom_range(1, 400)) : 16'($urandom);
    c.still_per = $urandom_range(0, 9) < 8 ? 8'($urandom_range(0, 12))
                                           : 8'($urandom_range(0, 40));
    c.accel_thr = 15'($urandom_range(0, 32767));
    c.pitch_win = $urandom_range(0, 9) == 0 ? 15'd0 : 15'($urandom_range(1, 18000));
    c.lift_tmo = $urandom_range(0, 9) < 8 ? 12'($urandom_range(0, 25)) : 12'($urandom);
    c.spin_tmo = $urandom_range(0, 9) < 8 ? 12'($urandom_range(0, 25)) : 12'($urandom);
    c.spin_thr = $urandom_range(0, 9) < 7 ? 16'($urandom_range(0, 3000)) : 16'($urandom);
    return c;
  endfunction

  // wheels inside the stillness threshold
  function automatic void pick_still(output logic signed [15:0] l, r);
    int thr, t, ml;
    thr = cfg_m.still_thr;
    if (thr == 0) begin
      l = 16'($urandom);
      r = 16'($urandom);
      return;
    end
    t = $urandom_range(0, 1) ? thr - 1 : int'($urandom_range(0, thr - 1));
    ml = $urandom_range(t > 32767 ? t - 32767 : 0, t < 32767 ? t : 32767);
    l = 16'($urandom_range(0, 1) ? -ml : ml);
    r = 16'($urandom_range(0, 1) ? -(t - ml) : t - ml);
  endfunction

  function automatic void pick_lift(input bit hit, output logic signed [15:0] a, p);
    int thr, win, m;
    thr = cfg_m.accel_thr;
    win = cfg_m.pitch_win;
    if (hit) begin
      if (thr < 32767)
        a = 16'($urandom_range(0, 1) ? thr + 1 : int'($urandom_range(thr + 1, 32767)));
      else
        a = 16'sd32767;
      if (win > 0) p = 16'(int'($urandom_range(0, 2 * win - 2)) - (win - 1));
      else p = 16'sd0;
    end else if ($urandom_range(0, 1)) begin
      a = 16'($urandom_range(0, 1) ? thr : int'($urandom_range(0, thr + 32768)) - 32768);
      p = 16'(int'($urandom_range(0, 36000)) - 18000);
    end else begin
      // accel may be high, pitch on or past the window edge
      a = 16'($urandom);
      m = $urandom_range(win < 18000 ? win : 18000, 18000);
      p = 16'($urandom_range(0, 1) ? -m : m);
    end
  endfunction

  function automatic void pick_spin(input bit hit, output logic signed [15:0] l, r);
    int thr, m, s, lo, hi, lv;
    thr = cfg_m.spin_thr;
    if (hit) m = $urandom_range(0, 1) ? thr + 1 : int'($urandom_range(thr + 1, 65536));
    else m = $urandom_range(0, 1) ? thr : int'($urandom_range(0, thr));
    // only a negative sum reaches 65535 and beyond
    s = (m > 65534 || $urandom_range(0, 1)) ? -m : m;
    lo = s - 32767 > -32768 ? s - 32767 : -32768;
    hi = s + 32768 < 32767 ? s + 32768 : 32767;
    lv = lo + int'($urandom_range(0, hi - lo));
    l = 16'(lv);
    r = 16'(s - lv);
  endfunction

  // steers each period by the predicted phase so sequences get deep
  task automatic send_guided(input int unsigned noise_pct, lift_pct, spin_pct);
    logic signed [15:0] l, r, a, p;
    l = 16'($urandom);
    r = 16'($urandom);
    a = 16'($urandom);
    p = 16'(int'($urandom_range(0, 36000)) - 18000);
    if ($urandom_range(0, 99) >= noise_pct) begin
      case (phase_m)
        PH_STILL: begin
          pick_still(l, r);
          if ($urandom_range(0, 9) < 3) pick_lift(1'b1, a, p);
        end
        PH_LIFT: begin
          pick_lift($urandom_range(0, 99) < lift_pct, a, p);
          if ($urandom_range(0, 9) < 3) pick_spin(1'b1, l, r);
        end
        PH_SPIN: pick_spin($urandom_range(0, 99) < spin_pct, l, r);
        default: ;
      endcase
    end
    send_period(l, r, a, p);
  endtask

  // reset values: field extremes and each threshold edge
  task automatic test_defaults();
    send_period(16'sd32767, 16'sd32767, 16'sd32767, 16'sd18000);
    send_period(16'h8000, 16'h8000, 16'h8000, -16'sd18000);
    repeat (5) send_period(-16'sd15, 16'sd14, 16'sd0, 16'sd0);
    send_period(16'sd15, 16'sd15, 16'sd0, 16'sd0);     // sum 30 is not still
    repeat (11) send_period(-16'sd15, 16'sd14, -16'sd1, 16'sd1);
    send_period(16'sd0, 16'sd0, 16'sd26000, 16'sd0);   // accel not above
    send_period(16'sd0, 16'sd0, 16'sd26001, 16'sd2000); // pitch on edge
    send_period(16'sd0, 16'sd0, 16'sd26001, -16'sd1999);
    send_period(16'sd35, 16'sd35, 16'sd0, 16'sd0);     // spin sum 70, not above
    send_period(-16'sd36, -16'sd35, 16'sd0, 16'sd0);
  endtask

  // short timeouts: kept counters, timeout plus success, full fall-through
  task automatic test_special_cases();
    cfg_t c;
    c = '{still_thr: 16'd30, still_per: 8'd0, accel_thr: 15'd100, pitch_win: 15'd500,
          lift_tmo: 12'd1, spin_tmo: 12'd1, spin_thr: 16'd10};
    load_settings(c, 1'b0);
    send_period(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_period(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_period(16'sd1, 16'sd1, 16'sd101, 16'sd0);
    send_period(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_period(16'sd6, 16'sd6, 16'sd0, 16'sd0);
    send_period(16'sd12, 16'sd5, 16'sd101, 16'sd0);    // still, lift, spin at once
    send_period(16'sd12, 16'sd5, 16'sd101, -16'sd500);
    send_period(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_period(16'sd0, 16'sd0, 16'sd101, 16'sd499);
    send_period(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_period(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_period(-16'sd6, -16'sd5, 16'sd0, 16'sd0);
    c.lift_tmo = 12'd0;
    c.spin_tmo = 12'd0;
    load_settings(c, 1'b0);
    repeat (30) send_guided(10, 50, 50);
  endtask

  task automatic test_cfg_extremes();
    cfg_t c;
    c = '0;
    load_settings(c, 1'b0);
    repeat (30) send_guided(20, 50, 50);
    c = '{16'hFFFF, 8'hFF, 15'h7FFF, 15'd18000, 12'hFFF, 12'hFFF, 16'hFFFF};
    load_settings(c, 1'b1);
    repeat (300) send_guided(0, 50, 50);
    c.accel_thr = 15'd32766;
    load_settings(c, 1'b1);
    repeat (40) send_guided(0, 50, 50);
  endtask

  task automatic test_random_phases();
    int unsigned noise, lift, spin;
    repeat (12) begin
      load_settings(rand_cfg(), 1'($urandom_range(0, 1)));
      gap_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
      stall_pct = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(5, 40);
      noise = $urandom_range(0, 20);
      lift = $urandom_range(5, 60);
      spin = $urandom_range(5, 60);
      repeat (100) send_guided(noise, lift, spin);
    end
  endtask

  // sender holds off until the result queue runs dry
  task automatic test_drain_pause();
    gap_pct = 15;
    stall_pct = 25;
    load_settings(rand_cfg(), 1'b0);
    repeat (5) begin
      repeat (20) send_guided(10, 40, 40);
      wait_drained();
    end
  endtask

  task automatic test_no_idle();
    gap_pct = 0;
    stall_pct = 0;
    load_settings(rand_cfg(), 1'b0);
    repeat (150) send_guided(5, 40, 40);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_special_cases();
    test_cfg_extremes();
    test_random_phases();
    test_drain_pause();
    test_no_idle();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
